// ----- rtl/sbm_pkg.sv -----
// ----------------------------------------------------------------------------
// sbm_pkg: shared types and constants for the signature byte stream matcher
// Table sizes, derived widths, request kinds and the match queue entry.
// ----------------------------------------------------------------------------
package sbm_pkg;

  // Table and offset sizing
  localparam int NUM_SIGS    = 8;
  localparam int MAX_SIG_LEN = 16;
  localparam int OFFSET_BITS = 16;
  localparam int MAX_REPORTS = 8;

  // Derived widths
  localparam int SIG_W   = (NUM_SIGS > 1) ? $clog2(NUM_SIGS) : 1;
  localparam int BIDX_W  = (MAX_SIG_LEN > 1) ? $clog2(MAX_SIG_LEN) : 1;
  localparam int LEN_W   = $clog2(MAX_SIG_LEN + 1);
  localparam int SEEN_W  = OFFSET_BITS + 1;
  localparam int RPT_W   = (MAX_REPORTS > 1) ? $clog2(MAX_REPORTS) : 1;

  // Request field widths
  localparam int KIND_W     = 2;
  localparam int SIG_IDX_W  = 3;
  localparam int BYTE_IDX_W = 4;
  localparam int SIG_LEN_W  = 5;

  // Queue depth between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Offset limits
  localparam logic [SEEN_W-1:0] OFFSET_MAX = SEEN_W'((64'd1 << OFFSET_BITS) - 64'd1);
  localparam logic [SEEN_W-1:0] SEEN_MAX   = OFFSET_MAX + SEEN_W'(MAX_SIG_LEN);

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_WR_BYTE = 2'd0,
    KIND_WR_LEN  = 2'd1,
    KIND_SCAN    = 2'd2,
    KIND_RESTART = 2'd3
  } sbm_kind_t;

  // One scanned byte with at least one hit
  typedef struct packed {
    logic [NUM_SIGS-1:0]            mask;
    logic [SEEN_W-1:0]              seen;
    logic [NUM_SIGS-1:0][LEN_W-1:0] lens;
  } sbm_entry_t;

endpackage

// ----- rtl/sbm_if.sv -----
// ----------------------------------------------------------------------------
// sbm_if: request and result channels of the signature byte stream matcher
// Valid/ready channels carrying the request fields and the match report.
// ----------------------------------------------------------------------------
interface sbm_in_if
  import sbm_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [SIG_IDX_W-1:0]  sig_index;
  logic [BYTE_IDX_W-1:0] byte_index;
  logic [7:0]            byte_value;
  logic [SIG_LEN_W-1:0]  sig_length;

  modport source (output valid, kind, sig_index, byte_index, byte_value, sig_length,
                  input ready);
  modport sink   (input valid, kind, sig_index, byte_index, byte_value, sig_length,
                  output ready);
endinterface

interface sbm_out_if
  import sbm_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [OFFSET_BITS-1:0] match_offset;
  logic [SIG_W-1:0]       match_sig;
  logic                   last;

  modport source (output valid, match_offset, match_sig, last, input ready);
  modport sink   (input valid, match_offset, match_sig, last, output ready);
endinterface

// ----- rtl/sbm_front.sv -----
// ----------------------------------------------------------------------------
// sbm_front: request intake, signature table and parallel window compare
// Applies table writes and stream restarts, shifts scan bytes into the
// window and pushes a hit mask with offset context into the match queue.
// ----------------------------------------------------------------------------
module sbm_front
  import sbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  sbm_in_if.sink     in_if,
  input  logic       q_full,
  output logic       q_push,
  output sbm_entry_t q_entry
);

  logic [7:0]                     pat_r [NUM_SIGS][MAX_SIG_LEN];
  logic [LEN_W-1:0]               len_r [NUM_SIGS];
  logic [LEN_W-1:0]               len_nxt [NUM_SIGS];
  logic [7:0]                     win_r [MAX_SIG_LEN];
  logic [7:0]                     win_nxt [MAX_SIG_LEN];
  logic [7:0]                     win_scan [MAX_SIG_LEN];
  logic [SEEN_W-1:0]              seen_r, seen_nxt, seen_scan;
  logic [NUM_SIGS-1:0]            hit;
  logic                           accept;
  logic                           pat_we;
  sbm_kind_t                      kind;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && in_if.ready;
  assign kind        = sbm_kind_t'(in_if.kind);

  // Window and count as they stand after a scan byte
  always_comb begin
    win_scan[0] = in_if.byte_value;
    for (int k = 1; k < MAX_SIG_LEN; k++) begin
      win_scan[k] = win_r[k-1];
    end
    seen_scan = (seen_r != SEEN_MAX) ? seen_r + SEEN_W'(1) : seen_r;
  end

  // Compare every signature at every length, then select its own length
  always_comb begin
    logic [MAX_SIG_LEN:0] by_len;
    logic                 ok;
    for (int s = 0; s < NUM_SIGS; s++) begin
      by_len[0] = 1'b0;
      for (int l = 1; l <= MAX_SIG_LEN; l++) begin
        ok = 1'b1;
        for (int j = 0; j < l; j++) begin
          ok = ok && (pat_r[s][j] == win_scan[l-1-j]);
        end
        by_len[l] = ok;
      end
      hit[s] = (len_r[s] != '0) && (seen_scan >= SEEN_W'(len_r[s])) && by_len[len_r[s]];
    end
  end

  // Decode request kind into next state
  always_comb begin
    win_nxt  = win_r;
    seen_nxt = seen_r;
    len_nxt  = len_r;
    pat_we   = 1'b0;
    q_push   = 1'b0;
    if (accept) begin
      unique case (kind)
        KIND_WR_BYTE: begin
          pat_we = (int'(in_if.sig_index) < NUM_SIGS) &&
                   (int'(in_if.byte_index) < MAX_SIG_LEN);
        end
        KIND_WR_LEN: begin
          if (int'(in_if.sig_index) < NUM_SIGS) begin
            len_nxt[SIG_W'(in_if.sig_index)] = (int'(in_if.sig_length) > MAX_SIG_LEN) ?
                                               LEN_W'(MAX_SIG_LEN) :
                                               LEN_W'(in_if.sig_length);
          end
        end
        KIND_SCAN: begin
          win_nxt  = win_scan;
          seen_nxt = seen_scan;
          q_push   = |hit;
        end
        KIND_RESTART: begin
          for (int k = 0; k < MAX_SIG_LEN; k++) begin
            win_nxt[k] = '0;
          end
          seen_nxt = '0;
        end
      endcase
    end
  end

  // Queue entry: hits, count after this byte and a length snapshot
  always_comb begin
    q_entry.mask = hit;
    q_entry.seen = seen_scan;
    for (int s = 0; s < NUM_SIGS; s++) begin
      q_entry.lens[s] = len_r[s];
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      for (int s = 0; s < NUM_SIGS; s++) begin
        len_r[s] <= '0;
      end
      for (int k = 0; k < MAX_SIG_LEN; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      seen_r <= seen_nxt;
      len_r  <= len_nxt;
      win_r  <= win_nxt;
    end
  end

  // Store signature bytes
  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_r[SIG_W'(in_if.sig_index)][BIDX_W'(in_if.byte_index)] <= in_if.byte_value;
    end
  end

endmodule

// ----- rtl/sbm_queue.sv -----
// ----------------------------------------------------------------------------
// sbm_queue: short match queue between front and back
// Register-based FIFO of hit entries, so each side can stall on its own.
// ----------------------------------------------------------------------------
module sbm_queue
  import sbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  sbm_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output sbm_entry_t head
);

  sbm_entry_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (int'(wr_r) == QUEUE_DEPTH - 1) ? '0 : wr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (int'(rd_r) == QUEUE_DEPTH - 1) ? '0 : rd_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

endmodule

// ----- rtl/sbm_back.sv -----
// ----------------------------------------------------------------------------
// sbm_back: match report sequencer
// Takes one hit entry at a time and hands out one report per set bit,
// lowest signature first, marking the last report of the byte.
// ----------------------------------------------------------------------------
module sbm_back
  import sbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_not_empty,
  input  sbm_entry_t q_head,
  output logic       q_pop,
  sbm_out_if.source  out_if
);

  logic              w_valid_r, w_valid_nxt;
  sbm_entry_t        w_ent_r, w_ent_nxt;
  logic [RPT_W-1:0]  cnt_r, cnt_nxt;
  logic [SIG_W-1:0]  sel;
  logic [NUM_SIGS-1:0] rest;
  logic [SEEN_W-1:0] start;
  logic              is_last;
  logic              accept;
  logic              take;

  // Pick the lowest pending signature
  always_comb begin
    sel = '0;
    for (int s = NUM_SIGS - 1; s >= 0; s--) begin
      if (w_ent_r.mask[s]) begin
        sel = SIG_W'(s);
      end
    end
    rest      = w_ent_r.mask & ~(NUM_SIGS'(1) << sel);
    is_last   = (rest == '0) || (cnt_r == RPT_W'(MAX_REPORTS - 1));
    start     = w_ent_r.seen - SEEN_W'(w_ent_r.lens[sel]);
  end

  assign out_if.valid        = w_valid_r;
  assign out_if.match_sig    = sel;
  assign out_if.match_offset = OFFSET_BITS'((start > OFFSET_MAX) ? OFFSET_MAX : start);
  assign out_if.last         = is_last;

  assign accept = out_if.valid && out_if.ready;
  assign take   = !w_valid_r || (accept && is_last);
  assign q_pop  = take && q_not_empty;

  // Load a new entry or drop the reported bit
  always_comb begin
    w_valid_nxt = w_valid_r;
    w_ent_nxt   = w_ent_r;
    cnt_nxt     = cnt_r;
    if (take) begin
      w_valid_nxt = q_not_empty;
      w_ent_nxt   = q_head;
      cnt_nxt     = '0;
    end else if (accept) begin
      w_ent_nxt.mask = rest;
      cnt_nxt        = cnt_r + RPT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_valid_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      w_valid_r <= w_valid_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_ent_r <= w_ent_nxt;
  end

  // A held entry always has a pending hit, and the reported one is set
  a_pending_hit: assert property (@(posedge clk) disable iff (!rst_n)
    w_valid_r |-> (w_ent_r.mask != '0) && w_ent_r.mask[sel])
    else $error("sbm_back: held entry without pending hit");

  // A non-final report keeps the entry and advances the report count
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_last) |=> w_valid_r && (cnt_r == $past(cnt_r) + RPT_W'(1)))
    else $error("sbm_back: entry lost before its last report");

  // A reported match never starts past the bytes counted for it
  a_start_range: assert property (@(posedge clk) disable iff (!rst_n)
    w_valid_r |-> (SEEN_W'(w_ent_r.lens[sel]) <= w_ent_r.seen))
    else $error("sbm_back: match length exceeds bytes scanned");

endmodule

// ----- rtl/signature_byte_stream_matcher.sv -----
// ----------------------------------------------------------------------------
// signature_byte_stream_matcher: multi-signature byte stream matcher
// Loads a table of byte signatures and reports every place in the stream
// where a whole enabled signature ends.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while the hit queue is not full:
// signature byte writes, length writes (0 disables an entry, above the
// maximum saturates), scan bytes and stream restarts. Every scan byte is
// compared against all signatures at once in the intake stage, so intake
// runs at one byte per cycle. A byte that hits k signatures gets k reports
// (at most MAX_REPORTS), one report per cycle while the output is ready,
// lowest signature index first, with last set on the final one; its hit
// entry is registered in the queue, then in the sequencer's holding register
// before its first report is offered. The two-entry hit queue between intake
// and the report sequencer means intake stalls only when that queue is full
// and reports are still waiting. Bytes without hits and table writes produce
// no report. Offsets count from the latest restart and saturate at all ones.
// ----------------------------------------------------------------------------
module signature_byte_stream_matcher
  import sbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  sbm_in_if.sink     in_if,
  sbm_out_if.source  out_if
);

  logic       q_push, q_pop, q_full, q_not_empty;
  sbm_entry_t q_entry, q_head;

  // Intake, table and compare
  sbm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  // Hit queue
  sbm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // Report sequencer
  sbm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_if      (out_if)
  );

endmodule
